[rtl/aqr_pkg.sv]
// Shared types, constants and helpers for the quaternion box rotator.
package aqr_pkg;

  localparam int QUAT_FRAC_BITS = 14;
  localparam int CORNER_COUNT   = 8;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [15:0] quat_t;
  typedef logic signed [47:0] prod_t;
  typedef logic signed [35:0] tval_t;
  typedef logic signed [51:0] cprod_t;
  typedef logic signed [40:0] rsum_t;

  // First-stage products of one corner, already steered to lo or hi
  typedef struct packed {
    prod_t uy_vz;
    prod_t uz_vy;
    prod_t uz_vx;
    prod_t ux_vz;
    prod_t ux_vy;
    prod_t uy_vx;
    prod_t w_vx;
    prod_t w_vy;
    prod_t w_vz;
  } corner_prod_t;

  function automatic coord_t sat32(input rsum_t x);
    coord_t r;
    if (x > rsum_t'(32'sh7fffffff)) r = 32'sh7fffffff;
    else if (x < -rsum_t'(33'sh080000000)) r = 32'sh80000000;
    else r = coord_t'(x);
    return r;
  endfunction

  function automatic coord_t smin(input coord_t a, input coord_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic coord_t smax(input coord_t a, input coord_t b);
    return (b > a) ? b : a;
  endfunction

endpackage

[rtl/aqr_corner.sv]
// Rotation of one box corner from its first-stage products, three register stages.
module aqr_corner
  import aqr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  corner_prod_t prod,
  input  coord_t       v [3],
  input  quat_t        u [3],
  output logic         out_valid,
  output coord_t       r [3]
);

  logic   vb, vc;
  tval_t  t [3];
  coord_t vb_v [3];
  coord_t vc_v [3];
  quat_t  ub [3];
  cprod_t m [6];

  logic signed [49:0] s [3];
  logic signed [52:0] d [3];
  rsum_t              rs [3];

  always_comb begin
    s[0] = 50'(prod.uy_vz) - 50'(prod.uz_vy) + 50'(prod.w_vx);
    s[1] = 50'(prod.uz_vx) - 50'(prod.ux_vz) + 50'(prod.w_vy);
    s[2] = 50'(prod.ux_vy) - 50'(prod.uy_vx) + 50'(prod.w_vz);
    d[0] = 53'(m[0]) - 53'(m[1]);
    d[1] = 53'(m[2]) - 53'(m[3]);
    d[2] = 53'(m[4]) - 53'(m[5]);
    for (int a = 0; a < 3; a++) begin
      rs[a] = 41'(vc_v[a]) + 41'(d[a] >>> (QUAT_FRAC_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vb        <= in_valid;
      vc        <= vb;
      out_valid <= vc;
    end
    // floor by the quaternion fraction
    for (int a = 0; a < 3; a++) begin
      t[a]    <= tval_t'(s[a] >>> QUAT_FRAC_BITS);
      vb_v[a] <= v[a];
      ub[a]   <= u[a];
      vc_v[a] <= vb_v[a];
      r[a]    <= sat32(rs[a]);
    end
    m[0] <= cprod_t'(ub[1]) * cprod_t'(t[2]);
    m[1] <= cprod_t'(ub[2]) * cprod_t'(t[1]);
    m[2] <= cprod_t'(ub[2]) * cprod_t'(t[0]);
    m[3] <= cprod_t'(ub[0]) * cprod_t'(t[2]);
    m[4] <= cprod_t'(ub[0]) * cprod_t'(t[1]);
    m[5] <= cprod_t'(ub[1]) * cprod_t'(t[0]);
  end

endmodule

[rtl/aabb_quaternion_rotate.sv]
// Top level: rotates an axis-aligned box by a quaternion and rebounds it.
// Fully pipelined: a box may be started in every cycle and busy is always
// low. Each result appears on the new_* ports with done high for one cycle,
// after the product stage, three corner stages and two min/max reduction
// stages. The receiver cannot stall, so results must be taken as they come.
// Eight corners are rotated in parallel per box.
module aabb_quaternion_rotate
  import aqr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  coord_t box_min_x,
  input  coord_t box_min_y,
  input  coord_t box_min_z,
  input  coord_t box_max_x,
  input  coord_t box_max_y,
  input  coord_t box_max_z,
  input  quat_t  quat_x,
  input  quat_t  quat_y,
  input  quat_t  quat_z,
  input  quat_t  quat_w,
  output logic   done,
  output coord_t new_min_x,
  output coord_t new_min_y,
  output coord_t new_min_z,
  output coord_t new_max_x,
  output coord_t new_max_y,
  output coord_t new_max_z
);

  logic   v1;
  coord_t lo [3];
  coord_t hi [3];
  quat_t  u1 [3];
  // [0] lo, [1] hi
  prod_t  uy_vz [2], uz_vy [2], uz_vx [2], ux_vz [2], ux_vy [2], uy_vx [2];
  prod_t  w_v [2][3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
    lo[0] <= box_min_x; lo[1] <= box_min_y; lo[2] <= box_min_z;
    hi[0] <= box_max_x; hi[1] <= box_max_y; hi[2] <= box_max_z;
    u1[0] <= quat_x;    u1[1] <= quat_y;    u1[2] <= quat_z;
    uy_vz[0]  <= prod_t'(quat_y) * prod_t'(box_min_z);
    uy_vz[1]  <= prod_t'(quat_y) * prod_t'(box_max_z);
    uz_vy[0]  <= prod_t'(quat_z) * prod_t'(box_min_y);
    uz_vy[1]  <= prod_t'(quat_z) * prod_t'(box_max_y);
    uz_vx[0]  <= prod_t'(quat_z) * prod_t'(box_min_x);
    uz_vx[1]  <= prod_t'(quat_z) * prod_t'(box_max_x);
    ux_vz[0]  <= prod_t'(quat_x) * prod_t'(box_min_z);
    ux_vz[1]  <= prod_t'(quat_x) * prod_t'(box_max_z);
    ux_vy[0]  <= prod_t'(quat_x) * prod_t'(box_min_y);
    ux_vy[1]  <= prod_t'(quat_x) * prod_t'(box_max_y);
    uy_vx[0]  <= prod_t'(quat_y) * prod_t'(box_min_x);
    uy_vx[1]  <= prod_t'(quat_y) * prod_t'(box_max_x);
    w_v[0][0] <= prod_t'(quat_w) * prod_t'(box_min_x);
    w_v[1][0] <= prod_t'(quat_w) * prod_t'(box_max_x);
    w_v[0][1] <= prod_t'(quat_w) * prod_t'(box_min_y);
    w_v[1][1] <= prod_t'(quat_w) * prod_t'(box_max_y);
    w_v[0][2] <= prod_t'(quat_w) * prod_t'(box_min_z);
    w_v[1][2] <= prod_t'(quat_w) * prod_t'(box_max_z);
  end

  logic   cv [CORNER_COUNT];
  coord_t cr [CORNER_COUNT][3];

  for (genvar k = 0; k < CORNER_COUNT; k++) begin : g_corner
    localparam int BX = k & 1;
    localparam int BY = (k >> 1) & 1;
    localparam int BZ = (k >> 2) & 1;
    corner_prod_t p;
    coord_t       v [3];
    always_comb begin
      p.uy_vz = uy_vz[BZ];
      p.uz_vy = uz_vy[BY];
      p.uz_vx = uz_vx[BX];
      p.ux_vz = ux_vz[BZ];
      p.ux_vy = ux_vy[BY];
      p.uy_vx = uy_vx[BX];
      p.w_vx  = w_v[BX][0];
      p.w_vy  = w_v[BY][1];
      p.w_vz  = w_v[BZ][2];
      v[0] = (BX == 1) ? hi[0] : lo[0];
      v[1] = (BY == 1) ? hi[1] : lo[1];
      v[2] = (BZ == 1) ? hi[2] : lo[2];
    end
    aqr_corner u_corner (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v1),
      .prod     (p),
      .v        (v),
      .u        (u1),
      .out_valid(cv[k]),
      .r        (cr[k])
    );
  end

  // reduce eight corners to two, then to one
  logic   ve;
  coord_t mn [2][3];
  coord_t mx [2][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ve   <= 1'b0;
      done <= 1'b0;
    end else begin
      ve   <= cv[0];
      done <= ve;
    end
    for (int h = 0; h < 2; h++) begin
      for (int a = 0; a < 3; a++) begin
        mn[h][a] <= smin(smin(cr[4*h][a], cr[4*h+1][a]), smin(cr[4*h+2][a], cr[4*h+3][a]));
        mx[h][a] <= smax(smax(cr[4*h][a], cr[4*h+1][a]), smax(cr[4*h+2][a], cr[4*h+3][a]));
      end
    end
    new_min_x <= smin(mn[0][0], mn[1][0]);
    new_min_y <= smin(mn[0][1], mn[1][1]);
    new_min_z <= smin(mn[0][2], mn[1][2]);
    new_max_x <= smax(mx[0][0], mx[1][0]);
    new_max_y <= smax(mx[0][1], mx[1][1]);
    new_max_z <= smax(mx[0][2], mx[1][2]);
  end

endmodule

[tb/tb_aabb_quaternion_rotate.sv]
// Self-checking bench for the quaternion box rotator: directed table, then random boxes.
module tb_aabb_quaternion_rotate;
  import aqr_pkg::*;

  localparam int LATENCY    = 6;
  localparam int WDOG_LIMIT = 2000;
  localparam int N_RANDOM   = 1330;

  typedef struct {
    coord_t lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  } box_t;

  typedef struct {
    box_t   b;
    quat_t  qx, qy, qz, qw;
    bit     known;
    box_t   want;
  } stim_row_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   busy;
  coord_t box_min_x = '0, box_min_y = '0, box_min_z = '0;
  coord_t box_max_x = '0, box_max_y = '0, box_max_z = '0;
  quat_t  quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
  logic   done;
  coord_t new_min_x, new_min_y, new_min_z, new_max_x, new_max_y, new_max_z;

  box_t      rotated_boxes[$];
  stim_row_t plan[$];
  int        fails = 0;
  int        idle_pct = 0;
  int        wdog = 0;

  always #4 clk = ~clk;

  aabb_quaternion_rotate dut (.*);

  function automatic longint floor_rsh(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Rotate all eight corners and rebound them.
  function automatic box_t rotate_box(box_t b, quat_t qx, quat_t qy, quat_t qz, quat_t qw);
    longint lo[3], hi[3], u[3], w, v[3], t[3], c[3], r[3], mn[3], mx[3];
    box_t o;
    lo = '{longint'(b.lo_x), longint'(b.lo_y), longint'(b.lo_z)};
    hi = '{longint'(b.hi_x), longint'(b.hi_y), longint'(b.hi_z)};
    u  = '{longint'(qx), longint'(qy), longint'(qz)};
    w  = longint'(qw);
    for (int k = 0; k < CORNER_COUNT; k++) begin
      for (int a = 0; a < 3; a++) v[a] = k[a] ? hi[a] : lo[a];
      t[0] = floor_rsh(u[1]*v[2] - u[2]*v[1] + w*v[0], QUAT_FRAC_BITS);
      t[1] = floor_rsh(u[2]*v[0] - u[0]*v[2] + w*v[1], QUAT_FRAC_BITS);
      t[2] = floor_rsh(u[0]*v[1] - u[1]*v[0] + w*v[2], QUAT_FRAC_BITS);
      c[0] = floor_rsh(u[1]*t[2] - u[2]*t[1], QUAT_FRAC_BITS - 1);
      c[1] = floor_rsh(u[2]*t[0] - u[0]*t[2], QUAT_FRAC_BITS - 1);
      c[2] = floor_rsh(u[0]*t[1] - u[1]*t[0], QUAT_FRAC_BITS - 1);
      for (int a = 0; a < 3; a++) begin
        r[a] = clamp32(v[a] + c[a]);
        if (k == 0 || r[a] < mn[a]) mn[a] = r[a];
        if (k == 0 || r[a] > mx[a]) mx[a] = r[a];
      end
    end
    o.lo_x = coord_t'(mn[0]); o.lo_y = coord_t'(mn[1]); o.lo_z = coord_t'(mn[2]);
    o.hi_x = coord_t'(mx[0]); o.hi_y = coord_t'(mx[1]); o.hi_z = coord_t'(mx[2]);
    return o;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
      1, 2: return coord_t'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic quat_t rand_quat();
    case ($urandom_range(0, 4))
      0: return quat_t'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      1: return '0;
      2: return quat_t'($signed($urandom_range(0, 32768)) - 16384); // near unit range
      default: return quat_t'($urandom);
    endcase
  endfunction

  function automatic box_t mk_box(coord_t a, coord_t b, coord_t c,
                                  coord_t d, coord_t e, coord_t f);
    box_t x;
    x.lo_x = a; x.lo_y = b; x.lo_z = c; x.hi_x = d; x.hi_y = e; x.hi_z = f;
    return x;
  endfunction

  task automatic add_row(box_t b, quat_t qx, quat_t qy, quat_t qz, quat_t qw,
                         bit known, box_t want);
    stim_row_t s;
    s.b = b; s.qx = qx; s.qy = qy; s.qz = qz; s.qw = qw; s.known = known; s.want = want;
    plan.push_back(s);
  endtask

  // Receiver side: done is a single-cycle strobe, sampled at the edge.
  always @(posedge clk) begin
    box_t exp_box;
    if (!rst && done) begin
      if (rotated_boxes.size() == 0) begin
        $error("result with no box outstanding");
        fails++;
      end else begin
        exp_box = rotated_boxes.pop_front();
        if (new_min_x !== exp_box.lo_x) begin
          $error("new_min_x exp %0d got %0d", exp_box.lo_x, new_min_x); fails++;
        end
        if (new_min_y !== exp_box.lo_y) begin
          $error("new_min_y exp %0d got %0d", exp_box.lo_y, new_min_y); fails++;
        end
        if (new_min_z !== exp_box.lo_z) begin
          $error("new_min_z exp %0d got %0d", exp_box.lo_z, new_min_z); fails++;
        end
        if (new_max_x !== exp_box.hi_x) begin
          $error("new_max_x exp %0d got %0d", exp_box.hi_x, new_max_x); fails++;
        end
        if (new_max_y !== exp_box.hi_y) begin
          $error("new_max_y exp %0d got %0d", exp_box.hi_y, new_max_y); fails++;
        end
        if (new_max_z !== exp_box.hi_z) begin
          $error("new_max_z exp %0d got %0d", exp_box.hi_z, new_max_z); fails++;
        end
      end
    end
  end

  // Watchdog: cycles with neither a start beat nor a result.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("** aabb_quaternion_rotate: FAILED **");
      $finish;
    end
  end

  task automatic send_row(stim_row_t s);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    box_min_x <= s.b.lo_x; box_min_y <= s.b.lo_y; box_min_z <= s.b.lo_z;
    box_max_x <= s.b.hi_x; box_max_y <= s.b.hi_y; box_max_z <= s.b.hi_z;
    quat_x <= s.qx; quat_y <= s.qy; quat_z <= s.qz; quat_w <= s.qw;
    @(posedge clk);
    while (busy) @(posedge clk);
    rotated_boxes.push_back(s.known ? s.want : rotate_box(s.b, s.qx, s.qy, s.qz, s.qw));
  endtask

  initial begin
    box_t z, unit, full;
    stim_row_t s;
    int waited;
    z    = mk_box(0, 0, 0, 0, 0, 0);
    unit = mk_box(-32'sd65536, -32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536);
    full = mk_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    // Directed: zero quaternion leaves the box unchanged; extremes; inverted box.
    add_row(z, 0, 0, 0, 0, 1, z);
    add_row(unit, 0, 0, 0, 0, 1, unit);
    add_row(full, 0, 0, 0, 0, 1, full);
    add_row(unit, 0, 0, 0, 16'sd16384, 1, unit);
    add_row(full, 0, 0, 0, 16'sd16384, 1, full);
    add_row(z, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1, z);
    add_row(mk_box(5, 6, 7, -5, -6, -7), 0, 0, 0, 0, 1, mk_box(-5, -6, -7, 5, 6, 7));
    add_row(unit, 16'sd16384, 0, 0, 0, 0, z);
    add_row(unit, 0, 16'sd11585, 0, 16'sd11585, 0, z);
    add_row(unit, 0, 0, 16'sd11585, -16'sd11585, 0, z);
    add_row(full, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, z);
    add_row(full, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 0, z);
    add_row(full, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 0, z);
    add_row(mk_box(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                   32'sh80000000, 32'sh7fffffff, 32'sh80000000),
            16'sd9000, -16'sd9000, 16'sd5000, 16'sd7000, 0, z);
    add_row(mk_box(-1, -1, -1, 1, 1, 1), -16'sd1, 16'sd1, -16'sd1, 16'sd1, 0, z);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (plan[i]) send_row(plan[i]);
    start <= 1'b0;
    // Hold off until every outstanding box has come back.
    while (rotated_boxes.size() != 0) @(posedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      case ((i * 5) / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 69;
        2: idle_pct = 18;
        3: idle_pct = 69;
        default: idle_pct = (i % 100 < 50) ? 0 : 40;
      endcase
      s.b = mk_box(rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord());
      s.qx = rand_quat(); s.qy = rand_quat(); s.qz = rand_quat(); s.qw = rand_quat();
      s.known = 0;
      send_row(s);
      if (idle_pct == 0 && $urandom_range(0, 19) == 0) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b0;
    waited = 0;
    while (rotated_boxes.size() != 0 && waited < 100 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (fails == 0 && rotated_boxes.size() == 0) begin
      $display("** aabb_quaternion_rotate: PASSED **");
    end else begin
      if (rotated_boxes.size() != 0) $error("%0d boxes never returned", rotated_boxes.size());
      $display("** aabb_quaternion_rotate: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/aqr_pkg.sv
rtl/aqr_corner.sv
rtl/aabb_quaternion_rotate.sv
tb/tb_aabb_quaternion_rotate.sv
